// ----- hdl/ppa_pkg.sv -----
// Shared types and constants for the polygon perimeter and area block.
package ppa_pkg;

  localparam int unsigned COORD_W      = 16;
  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 2);
  localparam int unsigned SQ_W         = 2 * COORD_W + 2;
  localparam int unsigned RAD_W        = SQ_W + 2 * FRAC_BITS;
  localparam int unsigned ROOT_W       = RAD_W / 2;
  localparam int unsigned REM_W        = ROOT_W + 2;
  localparam int unsigned ITER_W       = $clog2(ROOT_W);
  localparam int unsigned TERM_W       = 2 * COORD_W + 1;
  localparam int unsigned PERIM_W      = 35;
  localparam int unsigned AREA_W       = 43;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_MANY = 2'd2
  } status_e;

  typedef enum logic {
    FR_ACCEPT,
    FR_CLOSE
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIFF,
    BK_MUL,
    BK_SUM,
    BK_SQRT,
    BK_ACC,
    BK_OUT
  } back_state_e;

  // One edge to evaluate: length from (ax,ay) to (bx,by) and the cross term.
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic                      use_len;
    logic                      last;
    status_e                   status;
  } job_t;

endpackage

// ----- hdl/ppa_fifo.sv -----
// Short edge-job queue between the front and back sections.
module ppa_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppa_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ppa_pkg::job_t pop_data_o,
  output logic          empty_o
);
  import ppa_pkg::*;

  job_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o     = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/ppa_front.sv -----
// Front section: vertex intake, counting, classification into edge jobs.
module ppa_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_data_i,
  output logic                           cfg_ready_o,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [ppa_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [ppa_pkg::COORD_W-1:0] y_coord_i,
  input  logic                           last_vertex_i,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output ppa_pkg::job_t                  job_o
);
  import ppa_pkg::*;

  front_state_e              state_q, state_d;
  logic                      closed_mode_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          count_inc;
  logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  status_e                   status_q, status_d;
  logic                      accept;
  logic                      in_range;

  assign cfg_ready_o = 1'b1;
  assign in_range    = (count_q < CNT_W'(MAX_VERTICES));
  assign count_inc   = in_range ? count_q + 1'b1 : CNT_W'(MAX_VERTICES + 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_ACCEPT: if (accept && last_vertex_i) state_d = FR_CLOSE;
      FR_CLOSE:  if (!fifo_full_i) state_d = FR_ACCEPT;
      default:   state_d = FR_ACCEPT;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    push_o        = 1'b0;
    job_o.ax      = prev_x_q;
    job_o.ay      = prev_y_q;
    job_o.bx      = x_coord_i;
    job_o.by      = y_coord_i;
    job_o.use_len = 1'b1;
    job_o.last    = 1'b0;
    job_o.status  = ST_OK;
    unique case (state_q)
      FR_ACCEPT: begin
        in_ready_o = !fifo_full_i;
        push_o     = in_valid_i && !fifo_full_i && in_range && (count_q != '0);
      end
      FR_CLOSE: begin
        push_o        = !fifo_full_i;
        job_o.bx      = first_x_q;
        job_o.by      = first_y_q;
        job_o.use_len = closed_mode_q;
        job_o.last    = 1'b1;
        job_o.status  = status_q;
      end
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      count_d = count_inc;
      if (last_vertex_i) begin
        count_d = '0;
        priority if (count_inc > CNT_W'(MAX_VERTICES)) begin
          status_d = ST_MANY;
        end else if (count_inc < CNT_W'(3)) begin
          status_d = ST_FEW;
        end else begin
          status_d = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= FR_ACCEPT;
      closed_mode_q <= 1'b1;
      count_q       <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid_i) begin
        closed_mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (accept && in_range) begin
      prev_x_q <= x_coord_i;
      prev_y_q <= y_coord_i;
      if (count_q == '0) begin
        first_x_q <= x_coord_i;
        first_y_q <= y_coord_i;
      end
    end
  end

endmodule

// ----- hdl/ppa_back.sv -----
// Back section: edge length by bit-serial square root, shoelace sum, result register.
module ppa_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fifo_empty_i,
  input  ppa_pkg::job_t                   fifo_data_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ppa_pkg::PERIM_W-1:0]     perimeter_q8_o,
  output logic [ppa_pkg::AREA_W-1:0]      area_doubled_o,
  output logic [1:0]                      status_o
);
  import ppa_pkg::*;

  back_state_e                 state_q, state_d;
  job_t                        job_q;
  logic signed [COORD_W:0]     dx_q, dy_q;
  logic signed [2*COORD_W+1:0] prod_dx, prod_dy;
  logic signed [2*COORD_W-1:0] prod_1, prod_2;
  logic [2*COORD_W:0]          sq_dx_q, sq_dy_q;
  logic signed [2*COORD_W-1:0] p1_q, p2_q;
  logic [SQ_W-1:0]             sq_sum;
  logic signed [TERM_W-1:0]    term_q;
  logic [RAD_W-1:0]            rad_q;
  logic [REM_W-1:0]            rem_q, rem_shift, trial;
  logic [ROOT_W-1:0]           root_q;
  logic [ITER_W-1:0]           iter_q;
  logic                        root_bit;
  logic [PERIM_W-1:0]          perim_q;
  logic [PERIM_W:0]            perim_add;
  logic signed [AREA_W-1:0]    cross_q;
  logic                        out_valid_q;
  logic                        load_out;
  logic                        sqrt_done;
  logic [PERIM_W-1:0]          perim_out_q;
  logic [AREA_W-1:0]           area_out_q;
  status_e                     status_out_q;

  assign prod_dx   = (2*COORD_W+2)'(dx_q) * (2*COORD_W+2)'(dx_q);
  assign prod_dy   = (2*COORD_W+2)'(dy_q) * (2*COORD_W+2)'(dy_q);
  assign prod_1    = (2*COORD_W)'(job_q.ax) * (2*COORD_W)'(job_q.by);
  assign prod_2    = (2*COORD_W)'(job_q.bx) * (2*COORD_W)'(job_q.ay);
  assign sq_sum    = SQ_W'(sq_dx_q) + SQ_W'(sq_dy_q);
  assign rem_shift = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial     = {root_q, 2'b01};
  assign root_bit  = (rem_shift >= trial);
  assign sqrt_done = (iter_q == ITER_W'(ROOT_W - 1));
  assign perim_add = {1'b0, perim_q}
                   + (job_q.use_len ? (PERIM_W + 1)'(root_q) : '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!fifo_empty_i) state_d = BK_DIFF;
      BK_DIFF: state_d = BK_MUL;
      BK_MUL:  state_d = BK_SUM;
      BK_SUM:  state_d = BK_SQRT;
      BK_SQRT: if (sqrt_done) state_d = BK_ACC;
      BK_ACC:  state_d = job_q.last ? BK_OUT : BK_IDLE;
      BK_OUT:  if (load_out) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: pop_o = !fifo_empty_i;
      BK_OUT:  load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      perim_q     <= '0;
      cross_q     <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == BK_ACC) begin
        perim_q <= perim_add[PERIM_W] ? '1 : perim_add[PERIM_W-1:0];
        cross_q <= cross_q + AREA_W'(term_q);
      end else if (load_out) begin
        perim_q <= '0;
        cross_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        job_q <= fifo_data_i;
      end
      BK_DIFF: begin
        dx_q <= {job_q.ax[COORD_W-1], job_q.ax} - {job_q.bx[COORD_W-1], job_q.bx};
        dy_q <= {job_q.ay[COORD_W-1], job_q.ay} - {job_q.by[COORD_W-1], job_q.by};
      end
      BK_MUL: begin
        sq_dx_q <= prod_dx[2*COORD_W:0];
        sq_dy_q <= prod_dy[2*COORD_W:0];
        p1_q    <= prod_1;
        p2_q    <= prod_2;
      end
      BK_SUM: begin
        rad_q  <= RAD_W'(sq_sum) << (2 * FRAC_BITS);
        term_q <= TERM_W'(p1_q) - TERM_W'(p2_q);
        rem_q  <= '0;
        root_q <= '0;
        iter_q <= '0;
      end
      BK_SQRT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= root_bit ? rem_shift - trial : rem_shift;
        root_q <= {root_q[ROOT_W-2:0], root_bit};
        iter_q <= iter_q + 1'b1;
      end
      BK_ACC: ;
      BK_OUT: begin
        if (load_out) begin
          perim_out_q  <= perim_q;
          area_out_q   <= cross_q[AREA_W-1] ? AREA_W'(-cross_q) : AREA_W'(cross_q);
          status_out_q <= job_q.status;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign perimeter_q8_o = perim_out_q;
  assign area_doubled_o = area_out_q;
  assign status_o       = status_out_q;

endmodule

// ----- hdl/polygon_perimeter_area.sv -----
// Top level of the polygon perimeter and doubled-area block.
//
// Vertices enter on the input channel (in_valid_i/in_ready_o) as signed
// 16-bit x_coord_i, y_coord_i with last_vertex_i marking the final vertex.
// One result per polygon leaves on the output channel (out_valid_o/
// out_ready_i): perimeter with 8 fraction bits, absolute doubled area,
// status (ok, too few, too many vertices) and done_res_o, always 1.
// closed_mode is written on the cfg channel; cfg_ready_o is always high.
// The front section takes vertices and queues edge jobs; the back section
// works through each edge job in steps: difference, multiply, sum, the
// bit-serial square root, accumulate. The first vertex queues no job, each
// later vertex one edge job, and a last vertex also the closing edge job.
// The four-entry job queue lets the front take vertices while the square root
// is busy; the front stalls when the queue is full and while it closes a polygon.
// The result sits in an output register; a stalled receiver holds it there
// while the next polygon keeps being worked on, until its result is due.
// Reset empties the queue, clears the sums and count and sets closed_mode.
module polygon_perimeter_area (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [ppa_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [ppa_pkg::COORD_W-1:0] y_coord_i,
  input  logic                               last_vertex_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ppa_pkg::PERIM_W-1:0]        perimeter_q8_o,
  output logic [ppa_pkg::AREA_W-1:0]         area_doubled_o,
  output logic [1:0]                         status_o,
  output logic                               done_res_o
);
  import ppa_pkg::*;

  job_t push_job, pop_job;
  logic push, pop, fifo_full, fifo_empty;

  ppa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_ready_o   (cfg_ready_o),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .last_vertex_i (last_vertex_i),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  ppa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (fifo_empty)
  );

  ppa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (fifo_empty),
    .fifo_data_i    (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .perimeter_q8_o (perimeter_q8_o),
    .area_doubled_o (area_doubled_o),
    .status_o       (status_o)
  );

  assign done_res_o = 1'b1;

endmodule
